/* rtl/pfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and codes for the partition fit allocator
// Fit modes, commands, configuration register indexes, the scan candidate
// word handed from cell to cell, and the control state encoding.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Widest index and size the block supports (PARTS up to 256, SIZE_BITS up to 32)
  localparam int MAX_IDX_W  = 8;
  localparam int MAX_SIZE_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 2'd1;

  typedef enum logic [1:0] {
    FIT_BEST  = 2'd0,
    FIT_FIRST = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NONE  = 2'd3
  } fit_mode_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_t;

  // Best candidate seen so far in a scan
  typedef struct packed {
    logic                  found;
    logic [MAX_IDX_W-1:0]  idx;
    logic [MAX_SIZE_W-1:0] size;
  } cand_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

/* rtl/pfa_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_cell: one partition of the allocator chain
// Holds one free size. When the scan token arrives, compare the size with the
// request and the incoming candidate, then pass token and candidate on.
// ----------------------------------------------------------------------------
module pfa_cell import pfa_pkg::*; #(
  parameter int CELL_IDX  = 0,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 act_in,
  input  wire cand_t                cand_in,
  input  wire logic [SIZE_BITS-1:0] amt,
  input  wire fit_mode_t            mode,
  input  wire logic                 in_use,
  input  wire logic                 wr_en,
  input  wire logic [SIZE_BITS-1:0] wr_data,
  output logic                      act_out,
  output cand_t                     cand_out
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 fits;
  logic                 take;
  cand_t                cand_next;

  always_comb begin
    fits = in_use && (size_q >= amt) && (mode != FIT_NONE);
    take = 1'b0;
    if (fits) begin
      priority if (!cand_in.found) begin
        take = 1'b1;
      end else if (mode == FIT_BEST) begin
        take = MAX_SIZE_W'(size_q) < cand_in.size;
      end else if (mode == FIT_WORST) begin
        take = MAX_SIZE_W'(size_q) > cand_in.size;
      end else begin
        take = 1'b0;
      end
    end
    cand_next = cand_in;
    if (take) begin
      cand_next.found = 1'b1;
      cand_next.idx   = MAX_IDX_W'(CELL_IDX);
      cand_next.size  = MAX_SIZE_W'(size_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_q  <= '0;
      act_out <= 1'b0;
    end else begin
      if (wr_en) begin
        size_q <= wr_data;
      end
      act_out <= act_in;
    end
  end

  // Candidate payload; only meaningful behind the token
  always_ff @(posedge clk) begin
    if (act_in) begin
      cand_out <= cand_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/partition_fit_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// partition_fit_allocator: fixed partition placement, best/first/worst fit
// A chain of cells holds one partition free size each. Load words write a
// size; allocate words send a scan token down the chain and place the request
// in the partition chosen by the fit mode, then shrink that partition.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | in_valid / in_stall    | cmd, part_index, amount
//  out      | output    | out_valid / out_stall  | granted, chosen_part,
//           |           |                        | remaining_free
//  cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  An allocate word passes from accept through the scan_go register; the
//  scan token visits one cell per clock, then ST_FINISH commits the write-back.
//  A load word goes straight to ST_FINISH. One word is in flight at a time.
//  Reset (rst, synchronous) clears all free sizes, fit_mode and
//  partition_count. A stalled result holds the commit until the output
//  register frees; the input stays stalled for that time.
//
module partition_fit_allocator import pfa_pkg::*; #(
  parameter int PARTS     = 16,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input words
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  cmd,
  input  wire logic [3:0]            part_index,
  input  wire logic [15:0]           amount,
  // result words
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       granted,
  output logic [3:0]                 chosen_part,
  output logic [15:0]                remaining_free,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  state_t               state;
  state_t               state_next;

  // configuration registers
  fit_mode_t            fit_mode;
  logic [4:0]           partition_count;

  // latched input word
  cmd_t                 cmd_q;
  logic [3:0]           idx_q;
  logic [SIZE_BITS-1:0] amt_q;

  // scan chain: token and candidate, one stage per cell
  logic [PARTS:0]       act;
  logic                 scan_go;
  cand_t                chain [PARTS+1];
  logic [PARTS-1:0]     in_use;
  logic [PARTS-1:0]     wr_en;
  logic [SIZE_BITS-1:0] wr_data;

  logic                 accept;
  logic                 start;
  logic                 commit;
  logic                 load_ok;
  logic [SIZE_BITS-1:0] alloc_left;
  cand_t                tail;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign tail      = chain[PARTS];
  assign chain[0]  = '0;
  assign act[0]    = scan_go;

  // A load only lands inside the table
  assign load_ok    = (32'(idx_q) < PARTS);
  assign alloc_left = SIZE_BITS'(tail.size) - amt_q;
  assign wr_data    = (cmd_q == CMD_LOAD) ? amt_q : alloc_left;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode        <= FIT_BEST;
      partition_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIT_MODE:   fit_mode        <= fit_mode_t'(cfg_data[1:0]);
        CFG_PART_COUNT: partition_count <= cfg_data[4:0];
        default:        ;
      endcase
    end
  end

  // Control: idle, scan the chain (allocate only; a load skips the scan), then commit when the output frees
  always_comb begin
    state_next = state;
    start      = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(cmd) == CMD_ALLOC) begin
            start      = 1'b1;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (act[PARTS]) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      scan_go <= 1'b0;
    end else begin
      state   <= state_next;
      scan_go <= start;
    end
  end

  // Hold the accepted word for the whole operation
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(cmd);
      idx_q <= part_index;
      amt_q <= SIZE_BITS'(amount);
    end
  end

  // Cells: partition k is in use below partition_count, and is written on
  // commit when it is the load target or the placed partition
  for (genvar k = 0; k < PARTS; k++) begin : g_cell
    assign in_use[k] = (32'(partition_count) > k);
    assign wr_en[k]  = commit && ((cmd_q == CMD_LOAD)
                                  ? (load_ok && (32'(idx_q) == k))
                                  : (tail.found && (32'(tail.idx) == k)));

    pfa_cell #(
      .CELL_IDX  (k),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .act_in   (act[k]),
      .cand_in  (chain[k]),
      .amt      (amt_q),
      .mode     (fit_mode),
      .in_use   (in_use[k]),
      .wr_en    (wr_en[k]),
      .wr_data  (wr_data),
      .act_out  (act[k+1]),
      .cand_out (chain[k+1])
    );
  end

  // Result register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (cmd_q == CMD_LOAD) begin
        granted        <= load_ok;
        chosen_part    <= load_ok ? idx_q : 4'd0;
        remaining_free <= load_ok ? 16'(amt_q) : 16'd0;
      end else begin
        granted        <= tail.found;
        chosen_part    <= tail.found ? 4'(tail.idx) : 4'd0;
        remaining_free <= tail.found ? 16'(alloc_left) : 16'd0;
      end
    end
  end

  // Only one scan token is ever in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(act))
    else $error("more than one scan token in the chain");

  // The chain is quiet whenever the block is idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (act == '0))
    else $error("scan token present while idle");

  // The token reaches the tail only during a scan
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    act[PARTS] |-> (state == ST_SCAN))
    else $error("scan finished outside of scan state");

  // A commit always presents a result next cycle
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("commit did not load the result register");

  // A commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire
